@@ rtl/local_median_mad_outlier_seed_assert.svh @@
// Assertion macros shared by the outlier seed RTL.
`ifndef LOCAL_MEDIAN_MAD_OUTLIER_SEED_ASSERT_SVH
`define LOCAL_MEDIAN_MAD_OUTLIER_SEED_ASSERT_SVH
`ifndef SYNTH
`define LMMO_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LMMO_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LMMO_ASSERT(name, clk, rst, prop, msg)
`define LMMO_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif
`endif

@@ rtl/lmmo_pkg.sv @@
// Shared constants and types of the local median / MAD outlier seed block.
package lmmo_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HALF   = 3;
   localparam int DEF_PIXEL_BITS = 24;
   localparam int MAX_HEIGHT     = 4096;

   localparam int CFG_DIM_W   = 13;
   localparam int CFG_HALF_W  = 2;
   localparam int CFG_SIGMA_W = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int MIN_NEIGHBORS = 5;
   localparam int MAD_SCALE_Q16 = 97164;
   localparam int MAD_SCALE_W   = 17;
   localparam int MAD_SHIFT     = 28;
   localparam int COORD_OUT_W   = 12;
   localparam int RSP_DATA_W    = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_HALF_WINDOW  = 2'd2,
      CSR_SEED_SIGMA   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic step;
   } lmmo_sel_ctrl_type;

endpackage

@@ rtl/local_median_mad_outlier_seed.sv @@
// Local median / MAD outlier seed detector, top level.
// Pixels arrive in raster order; decisions leave h*W+h positions later, one per pixel,
// and drain items after the frame flush the tail. For an item that gives a decision,
// the window is fetched one tap per cycle from the single read port of the line ring,
// and median and MAD are each found in a pass of the bit-serial rank selector; the
// threshold product is formed in the MAD pass. No new item is taken until the
// decision has been loaded into the response register.
// The ring holds (2*MAX_HALF_WINDOW+2)*MAX_WIDTH entries and needs no clearing after reset.
// In the cycle after each configuration write no transaction is taken.
`include "local_median_mad_outlier_seed_assert.svh"
module local_median_mad_outlier_seed import lmmo_pkg::*; #(
   parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
   parameter int MAX_HALF_WINDOW = DEF_MAX_HALF,
   parameter int PIXEL_BITS      = DEF_PIXEL_BITS,
   localparam int REQ_W = ((PIXEL_BITS + 1 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // pixel_value, masked
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // pixel_x, pixel_y, is_seed
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int WIN    = (2 * MAX_HALF_WINDOW + 1) * (2 * MAX_HALF_WINDOW + 1);
   localparam int WORD_W = PIXEL_BITS + 1;
   localparam int CNT_W  = $clog2(WIN + 1);
   localparam int RING   = (2 * MAX_HALF_WINDOW + 2) * MAX_WIDTH;
   localparam int AW     = $clog2(RING);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int CW     = ((XW > YW) ? XW : YW) + 2;
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
   localparam int HTW    = $clog2(MAX_HEIGHT + 1);
   localparam int HW     = $clog2(MAX_HALF_WINDOW + 1);
   localparam int HEW    = (HW > CFG_HALF_W) ? HW : CFG_HALF_W;
   localparam int TW     = $clog2(2 * MAX_HALF_WINDOW + 1);
   localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int MK_W   = CFG_SIGMA_W + MAD_SCALE_W;
   localparam int ACC_W  = WORD_W + MK_W;
   localparam int SC_W   = $clog2(WORD_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_GATHER, ST_GLAST, ST_CHECK,
      ST_MED, ST_DEV, ST_RAW, ST_CMP, ST_OUT
   } state_type;

   typedef struct packed {
      logic vld;
      logic inr;
      logic centre;
   } tap_tag_type;

   // configuration
   logic [CFG_DIM_W-1:0]   cfg_width_ff;
   logic [CFG_DIM_W-1:0]   cfg_height_ff;
   logic [CFG_HALF_W-1:0]  cfg_half_ff;
   logic [CFG_SIGMA_W-1:0] cfg_sigma_ff;
   logic                   settle_ff;

   logic [WW-1:0]    w_eff;
   logic [HTW-1:0]   hgt_eff;
   logic [HW-1:0]    h_eff;
   logic [WW-1:0]    weff_ff;
   logic [HTW-1:0]   hgt_ff;
   logic [HW-1:0]    half_ff;
   logic [POS_W-1:0] total_ff;
   logic [AW-1:0]    lag_ff;
   logic [MK_W-1:0]  mk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= CFG_DIM_W'(4096);
         cfg_height_ff <= CFG_DIM_W'(4096);
         cfg_half_ff   <= CFG_HALF_W'(2);
         cfg_sigma_ff  <= CFG_SIGMA_W'(12288);
         settle_ff     <= 1'b1;
      end else begin
         settle_ff <= csr_we;
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata[CFG_DIM_W-1:0];
               CSR_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata[CFG_DIM_W-1:0];
               CSR_HALF_WINDOW:  cfg_half_ff   <= csr_wdata[CFG_HALF_W-1:0];
               CSR_SEED_SIGMA:   cfg_sigma_ff  <= csr_wdata[CFG_SIGMA_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (EW'(cfg_width_ff) > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         hgt_eff = HTW'(1);
      end else if (cfg_height_ff > CFG_DIM_W'(MAX_HEIGHT)) begin
         hgt_eff = HTW'(MAX_HEIGHT);
      end else begin
         hgt_eff = HTW'(cfg_height_ff);
      end
      if (cfg_half_ff == '0) begin
         h_eff = HW'(1);
      end else if (HEW'(cfg_half_ff) > HEW'(MAX_HALF_WINDOW)) begin
         h_eff = HW'(MAX_HALF_WINDOW);
      end else begin
         h_eff = HW'(cfg_half_ff);
      end
   end

   always_ff @(posedge clock) begin
      weff_ff  <= w_eff;
      hgt_ff   <= hgt_eff;
      half_ff  <= h_eff;
      total_ff <= POS_W'(w_eff) * POS_W'(hgt_eff);
      lag_ff   <= AW'(w_eff) * AW'(h_eff) + AW'(h_eff);
      mk_ff    <= MK_W'(cfg_sigma_ff) * MK_W'(MAD_SCALE_Q16);
   end

   // positions and control
   state_type          state_ff;
   logic [POS_W-1:0]   in_pos_ff, out_pos_ff;
   logic [AW-1:0]      iptr_ff, optr_ff;
   logic [XW-1:0]      cx_ff;
   logic [YW-1:0]      cy_ff;
   logic [AW-1:0]      taddr_ff, rowstart_ff;
   logic signed [CW-1:0] tx_ff, ty_ff;
   logic [TW-1:0]      ix_ff, iy_ff;
   tap_tag_type        pend_ff;
   logic [PIXEL_BITS:0] rd_ff;
   logic [PIXEL_BITS:0] ring_mem [RING];

   logic signed [PIXEL_BITS-1:0] val_ff [WIN];
   logic [WIN-1:0]     vld_ff;
   logic [CNT_W-1:0]   n_ff;
   logic signed [PIXEL_BITS-1:0] cv_ff;
   logic               cmask_ff;
   logic [SC_W-1:0]    step_cnt_ff;
   logic [WORD_W-1:0]  med_ff, raw_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic               seed_ff;
   logic               rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic               rsp_tlast_ff;

   // transaction intake
   logic             req_fire, frame_wrap, is_pixel, emit, mem_we;
   logic [POS_W-1:0] cur_in, cur_out;
   logic [AW-1:0]    cur_iptr, cur_optr, iptr_next;
   logic [XW-1:0]    cur_cx;
   logic [YW-1:0]    cur_cy;

   assign req_tready = (state_ff == ST_IDLE) && !settle_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign frame_wrap = (out_pos_ff >= total_ff) || (in_pos_ff > total_ff);
   assign cur_in     = frame_wrap ? '0 : in_pos_ff;
   assign cur_out    = frame_wrap ? '0 : out_pos_ff;
   assign cur_iptr   = frame_wrap ? '0 : iptr_ff;
   assign cur_optr   = frame_wrap ? '0 : optr_ff;
   assign cur_cx     = frame_wrap ? '0 : cx_ff;
   assign cur_cy     = frame_wrap ? '0 : cy_ff;
   assign is_pixel   = !req_tuser && (cur_in < total_ff);
   assign emit       = is_pixel ? ({1'b0, cur_in} >= {1'b0, cur_out} + (POS_W+1)'(lag_ff))
                                : (cur_in == total_ff);
   assign mem_we     = req_fire && is_pixel;
   assign iptr_next  = (cur_iptr == AW'(RING - 1)) ? '0 : cur_iptr + 1'b1;

   // window walk
   logic [TW-1:0]    h1, h2;
   logic             tap_centre, row_end, tap_last, tap_in, append;
   logic [AW-1:0]    taddr_inc, row_next, start_addr;
   logic [AW:0]      row_sum, start_sum;
   logic signed [CW-1:0] col_start, row_start;

   assign h1         = TW'(half_ff);
   assign h2         = TW'({half_ff, 1'b0});
   assign tap_centre = (ix_ff == h1) && (iy_ff == h1);
   assign row_end    = (ix_ff == h2);
   assign tap_last   = row_end && (iy_ff == h2);
   assign tap_in     = !tx_ff[CW-1] && (tx_ff < $signed(CW'(weff_ff)))
                    && !ty_ff[CW-1] && (ty_ff < $signed(CW'(hgt_ff)));
   assign taddr_inc  = (taddr_ff == AW'(RING - 1)) ? '0 : taddr_ff + 1'b1;
   assign row_sum    = {1'b0, rowstart_ff} + (AW+1)'(weff_ff);
   assign row_next   = (row_sum >= (AW+1)'(RING)) ? AW'(row_sum - (AW+1)'(RING)) : AW'(row_sum);
   assign start_sum  = {1'b0, optr_ff} + ((AW+1)'(RING) - (AW+1)'(lag_ff));
   assign start_addr = (start_sum >= (AW+1)'(RING)) ? AW'(start_sum - (AW+1)'(RING))
                                                   : AW'(start_sum);
   assign col_start  = CW'(cx_ff) - CW'(half_ff);
   assign row_start  = CW'(cy_ff) - CW'(half_ff);
   assign append     = pend_ff.vld && pend_ff.inr && !rd_ff[PIXEL_BITS];

   // rank selection
   lmmo_sel_ctrl_type sel_ctrl;
   logic [WORD_W-1:0] sel_words [WIN];
   logic              sel_bit, check_ok;
   logic signed [PIXEL_BITS-1:0] med_val;
   logic signed [WORD_W-1:0] dev_diff [WIN];
   logic signed [WORD_W-1:0] cen_diff;
   logic [ACC_W-1:0]  lhs;

   assign med_val  = {~med_ff[PIXEL_BITS-1], med_ff[PIXEL_BITS-2:0]};
   assign check_ok = !cmask_ff && (n_ff >= CNT_W'(MIN_NEIGHBORS));
   assign sel_ctrl.load = ((state_ff == ST_CHECK) && check_ok) || (state_ff == ST_DEV);
   assign sel_ctrl.step = (state_ff == ST_MED) || (state_ff == ST_RAW);

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         dev_diff[i] = {val_ff[i][PIXEL_BITS-1], val_ff[i]} - {med_val[PIXEL_BITS-1], med_val};
         if (state_ff == ST_DEV) begin
            sel_words[i] = dev_diff[i][WORD_W-1] ? WORD_W'(-dev_diff[i]) : WORD_W'(dev_diff[i]);
         end else begin
            // offset binary keeps signed order under an unsigned scan
            sel_words[i] = {1'b0, ~val_ff[i][PIXEL_BITS-1], val_ff[i][PIXEL_BITS-2:0]};
         end
      end
   end

   assign cen_diff = {cv_ff[PIXEL_BITS-1], cv_ff} - {med_val[PIXEL_BITS-1], med_val};
   assign lhs      = ACC_W'(cen_diff) << MAD_SHIFT;

   lmmo_select #(
      .WIN    (WIN),
      .WORD_W (WORD_W)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .sel_ctrl   (sel_ctrl),
      .load_words (sel_words),
      .load_valid (vld_ff),
      .load_rank  (n_ff >> 1),
      .sel_bit    (sel_bit)
   );

   // line ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[cur_iptr] <= req_tdata[PIXEL_BITS:0];
      end
      rd_ff <= ring_mem[taddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_pos_ff     <= '0;
         out_pos_ff    <= '0;
         iptr_ff       <= '0;
         optr_ff       <= '0;
         cx_ff         <= '0;
         cy_ff         <= '0;
         pend_ff       <= '0;
         vld_ff        <= '0;
         n_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pend_ff <= '{vld: (state_ff == ST_GATHER), inr: tap_in, centre: tap_centre};
         // the output state reloads the response register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         // collect the tap read in the previous cycle
         if (pend_ff.vld && pend_ff.centre) begin
            cv_ff    <= rd_ff[PIXEL_BITS-1:0];
            cmask_ff <= rd_ff[PIXEL_BITS];
         end
         if (append) begin
            n_ff <= n_ff + 1'b1;
            for (int i = 0; i < WIN; i++) begin
               if (n_ff == CNT_W'(i)) begin
                  val_ff[i] <= rd_ff[PIXEL_BITS-1:0];
                  vld_ff[i] <= 1'b1;
               end
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  in_pos_ff  <= is_pixel ? cur_in + 1'b1 : cur_in;
                  iptr_ff    <= is_pixel ? iptr_next : cur_iptr;
                  out_pos_ff <= cur_out;
                  optr_ff    <= cur_optr;
                  cx_ff      <= cur_cx;
                  cy_ff      <= cur_cy;
                  if (emit) begin
                     state_ff <= ST_SETUP;
                  end
               end
            end
            ST_SETUP: begin
               rowstart_ff <= start_addr;
               taddr_ff    <= start_addr;
               tx_ff       <= col_start;
               ty_ff       <= row_start;
               ix_ff       <= '0;
               iy_ff       <= '0;
               n_ff        <= '0;
               vld_ff      <= '0;
               state_ff    <= ST_GATHER;
            end
            ST_GATHER: begin
               if (tap_last) begin
                  state_ff <= ST_GLAST;
               end else if (row_end) begin
                  rowstart_ff <= row_next;
                  taddr_ff    <= row_next;
                  tx_ff       <= col_start;
                  ty_ff       <= ty_ff + 1'b1;
                  ix_ff       <= '0;
                  iy_ff       <= iy_ff + 1'b1;
               end else begin
                  taddr_ff <= taddr_inc;
                  tx_ff    <= tx_ff + 1'b1;
                  ix_ff    <= ix_ff + 1'b1;
               end
            end
            ST_GLAST: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               step_cnt_ff <= '0;
               if (check_ok) begin
                  state_ff <= ST_MED;
               end else begin
                  seed_ff  <= 1'b0;
                  state_ff <= ST_OUT;
               end
            end
            ST_MED: begin
               med_ff      <= {med_ff[WORD_W-2:0], sel_bit};
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (step_cnt_ff == SC_W'(WORD_W - 1)) begin
                  state_ff <= ST_DEV;
               end
            end
            ST_DEV: begin
               acc_ff      <= '0;
               step_cnt_ff <= '0;
               state_ff    <= ST_RAW;
            end
            ST_RAW: begin
               // accumulate raw MAD times sigma times the scale, MSB first
               raw_ff      <= {raw_ff[WORD_W-2:0], sel_bit};
               acc_ff      <= {acc_ff[ACC_W-2:0], 1'b0} + (sel_bit ? ACC_W'(mk_ff) : '0);
               step_cnt_ff <= step_cnt_ff + 1'b1;
               if (step_cnt_ff == SC_W'(WORD_W - 1)) begin
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               seed_ff  <= (raw_ff != '0) && !cen_diff[WORD_W-1] && (cen_diff != '0)
                        && (lhs > acc_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= RSP_DATA_W'({seed_ff, COORD_OUT_W'(cy_ff), COORD_OUT_W'(cx_ff)});
                  rsp_tlast_ff  <= (out_pos_ff == total_ff - 1'b1);
                  state_ff      <= ST_IDLE;
                  if (out_pos_ff + 1'b1 >= total_ff) begin
                     in_pos_ff  <= '0;
                     out_pos_ff <= '0;
                     iptr_ff    <= '0;
                     optr_ff    <= '0;
                     cx_ff      <= '0;
                     cy_ff      <= '0;
                  end else begin
                     out_pos_ff <= out_pos_ff + 1'b1;
                     optr_ff    <= (optr_ff == AW'(RING - 1)) ? '0 : optr_ff + 1'b1;
                     if (WW'(cx_ff) + 1'b1 == weff_ff) begin
                        cx_ff <= '0;
                        cy_ff <= cy_ff + 1'b1;
                     end else begin
                        cx_ff <= cx_ff + 1'b1;
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `LMMO_ASSERT(a_emit_behind_input, clock, reset, (state_ff == ST_SETUP) |-> (in_pos_ff > out_pos_ff), "decision ahead of input")
   `LMMO_ASSERT(a_out_in_frame, clock, reset, (state_ff == ST_OUT) |-> (out_pos_ff < total_ff), "decision outside frame")
   `LMMO_ASSERT(a_med_after_check, clock, reset, ((state_ff == ST_MED) && (step_cnt_ff == '0)) |-> ($past(state_ff) == ST_CHECK), "median pass without load")

endmodule

@@ rtl/lmmo_select.sv @@
// Bit-serial rank selector: finds the element of a given rank, MSB first.
`include "local_median_mad_outlier_seed_assert.svh"
module lmmo_select import lmmo_pkg::*; #(
   parameter int WIN    = 49,
   parameter int WORD_W = 25,
   localparam int CNT_W = $clog2(WIN + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  lmmo_sel_ctrl_type sel_ctrl,
   input  logic [WORD_W-1:0] load_words [WIN],
   input  logic [WIN-1:0]    load_valid,
   input  logic [CNT_W-1:0]  load_rank,
   output logic              sel_bit
);

   logic [WORD_W-1:0] words_ff [WIN];
   logic [WIN-1:0]    cand_ff;
   logic [CNT_W-1:0]  rank_ff;
   logic [WIN-1:0]    msb_col;
   logic [CNT_W-1:0]  zeros;

   always_comb begin
      for (int i = 0; i < WIN; i++) begin
         msb_col[i] = words_ff[i][WORD_W-1];
      end
   end

   // candidates with a zero in the current column rank below those with a one
   assign zeros   = CNT_W'($countones(cand_ff & ~msb_col));
   assign sel_bit = (zeros <= rank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
         rank_ff <= '0;
      end else if (sel_ctrl.load) begin
         cand_ff <= load_valid;
         rank_ff <= load_rank;
      end else if (sel_ctrl.step) begin
         if (sel_bit) begin
            cand_ff <= cand_ff & msb_col;
            rank_ff <= rank_ff - zeros;
         end else begin
            cand_ff <= cand_ff & ~msb_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN; i++) begin
         if (sel_ctrl.load) begin
            words_ff[i] <= load_words[i];
         end else if (sel_ctrl.step) begin
            words_ff[i] <= {words_ff[i][WORD_W-2:0], 1'b0};
         end
      end
   end

   `LMMO_ASSERT(a_rank_in_set, clock, reset, sel_ctrl.step |-> (32'(rank_ff) < $countones(cand_ff)), "rank outside candidate set")
   `LMMO_ASSERT(a_step_keeps_cand, clock, reset, sel_ctrl.step |=> (cand_ff != '0), "candidate set emptied")
   `LMMO_ASSERT_NEVER(a_load_step, clock, reset, sel_ctrl.load && sel_ctrl.step, "load and step together")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the local median / MAD outlier seed detector.
module testbench;
   import lmmo_pkg::*;

   localparam int RING_DEPTH  = (2 * DEF_MAX_HALF + 2) * DEF_MAX_WIDTH;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      bit        drain;
      bit [23:0] value;
      bit        masked;
   } pixel_item_type;

   typedef struct {
      bit [11:0] x;
      bit [11:0] y;
      bit        seed;
      bit        frame_end;
   } decision_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // pixel_value, masked
   logic        req_tuser;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // pixel_x, pixel_y, is_seed
   logic        rsp_tlast;
   logic        csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   local_median_mad_outlier_seed dut (.*);

   pixel_item_type pending_items[$];
   decision_type   expected_decisions[$];
   pixel_item_type held_item;
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          no_idle = 0;

   // shadow of the block's configuration and positions
   int          cur_width = 4096, cur_height = 4096, cur_half = 2;
   longint      cur_sigma = 12288;
   int          in_pos = 0, out_pos = 0;
   logic [24:0] line_ring [0:RING_DEPTH-1];

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int short_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic bit seed_decision(int cx, int cy);
      longint win[49];
      longint dev[49];
      longint k, med, raw, diff;
      logic [24:0] e, centre;
      int n, i, j;
      n = 0;
      centre = line_ring[(cy * cur_width + cx) % RING_DEPTH];
      if (centre[24]) return 0;
      for (int wy = cy - cur_half; wy <= cy + cur_half; wy++) begin
         if (wy < 0 || wy >= cur_height) continue;
         for (int wx = cx - cur_half; wx <= cx + cur_half; wx++) begin
            if (wx < 0 || wx >= cur_width) continue;
            e = line_ring[(wy * cur_width + wx) % RING_DEPTH];
            if (e[24]) continue;
            win[n] = longint'($signed(e[23:0]));
            n++;
         end
      end
      if (n < MIN_NEIGHBORS) return 0;
      for (i = 1; i < n; i++) begin
         k = win[i];
         for (j = i - 1; j >= 0 && win[j] > k; j--) win[j+1] = win[j];
         win[j+1] = k;
      end
      med = win[n/2];
      for (i = 0; i < n; i++) dev[i] = (win[i] < med) ? med - win[i] : win[i] - med;
      for (i = 1; i < n; i++) begin
         k = dev[i];
         for (j = i - 1; j >= 0 && dev[j] > k; j--) dev[j+1] = dev[j];
         dev[j+1] = k;
      end
      raw = dev[n/2];
      if (raw == 0) return 0;
      diff = longint'($signed(centre[23:0])) - med;
      if (diff <= 0) return 0;
      // products stay well below 2^63 at these widths
      return (diff << MAD_SHIFT) > raw * MAD_SCALE_Q16 * cur_sigma;
   endfunction

   task automatic predict_decision(pixel_item_type it);
      int total, lag;
      bit emit;
      decision_type d;
      total = cur_width * cur_height;
      lag = cur_half * cur_width + cur_half;
      if (out_pos >= total || in_pos > total) begin
         in_pos = 0;
         out_pos = 0;
      end
      if (!it.drain && in_pos < total) begin
         line_ring[in_pos % RING_DEPTH] = {it.masked, it.value};
         in_pos++;
         emit = (in_pos - 1) >= out_pos + lag;
      end else begin
         emit = (in_pos == total);
      end
      if (emit) begin
         d.x = 12'(out_pos % cur_width);
         d.y = 12'(out_pos / cur_width);
         d.seed = seed_decision(out_pos % cur_width, out_pos / cur_width);
         d.frame_end = (out_pos == total - 1);
         expected_decisions.insert(expected_decisions.size(), d);
         out_pos++;
         if (out_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
         end
      end
   endtask

   // driver: feed pending items, predict on each accepted transaction
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
         req_tuser  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) predict_decision(held_item);
         if (send_gap > 0 || pending_items.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_tvalid <= 0;
         end else begin
            held_item = pending_items.pop_front();
            req_tvalid <= 1;
            req_tuser  <= held_item.drain;
            req_tdata  <= {7'd0, held_item.masked, held_item.value};
            send_gap = short_gap();
         end
      end
   end

   // monitor: compare each accepted decision with the oldest prediction
   int stall = 0;
   always @(posedge clock) begin
      decision_type d;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decisions.size() == 0) begin
               $display("%0t: unexpected decision x=%0d y=%0d", $time,
                        rsp_tdata[11:0], rsp_tdata[23:12]);
               mismatches++;
            end else begin
               d = expected_decisions.pop_front();
               if (rsp_tdata[11:0] !== d.x || rsp_tdata[23:12] !== d.y ||
                   rsp_tdata[24] !== d.seed || rsp_tlast !== d.frame_end) begin
                  $display("%0t: expected x=%0d y=%0d seed=%0d end=%0d, got x=%0d y=%0d seed=%0d end=%0d",
                           $time, d.x, d.y, d.seed, d.frame_end, rsp_tdata[11:0],
                           rsp_tdata[23:12], rsp_tdata[24], rsp_tlast);
                  mismatches++;
               end
            end
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else begin
            stall = short_gap();
            rsp_tready <= (stall == 0);
         end
      end
   end

   task automatic write_reg(csr_index_type idx, int data);
      @(posedge clock);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_we    <= 0;
      case (idx)
         CSR_IMAGE_WIDTH:  cur_width  = data;
         CSR_IMAGE_HEIGHT: cur_height = data;
         CSR_HALF_WINDOW:  cur_half   = data;
         default:          cur_sigma  = data;
      endcase
   endtask

   task automatic configure(int w, int hgt, int h, int sigma);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, hgt);
      write_reg(CSR_HALF_WINDOW, h);
      write_reg(CSR_SEED_SIGMA, sigma);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_decisions.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic bit [23:0] clamp24(longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return v[23:0];
   endfunction

   // one frame of random content; returns the number of frame and tail items queued, early drains not counted
   function automatic int queue_frame(int style, int mask_pct);
      pixel_item_type it;
      int total, lag, tail, count;
      longint base;
      total = cur_width * cur_height;
      lag = cur_half * cur_width + cur_half;
      tail = (total < lag) ? total : lag;
      count = 0;
      base = longint'($signed(24'($urandom)));
      if (style == 0) base = base / 64;
      for (int i = 0; i < total + tail; i++) begin
         if (i < total && $urandom_range(0, 99) < 4) begin
            // drain before the frame is complete: ignored
            it.drain = 1;
            it.value = 24'($urandom);
            it.masked = 1'($urandom_range(0, 1));
            pending_items.insert(pending_items.size(), it);
         end
         it.drain = (i >= total) ? 1'($urandom_range(0, 1)) : 1'b0;
         it.masked = ($urandom_range(0, 99) < mask_pct);
         case (style)
            0: it.value = clamp24(base + $urandom_range(0, 255) - 128 +
                          (($urandom_range(0, 99) < 10) ? $urandom_range(1000, 900000) : 0));
            1: it.value = 24'($urandom);
            default: it.value = ($urandom_range(0, 99) < 10) ? 24'($urandom) : base[23:0];
         endcase
         pending_items.insert(pending_items.size(), it);
         count++;
      end
      return count;
   endfunction

   task automatic queue_pixel(bit [23:0] v, bit m);
      pixel_item_type it;
      it.drain = 0;
      it.value = v;
      it.masked = m;
      pending_items.insert(pending_items.size(), it);
   endtask

   initial begin
      pixel_item_type it;
      int random_count, sig;
      reset = 1;
      csr_we = 0;
      csr_addr = CSR_IMAGE_WIDTH;
      csr_wdata = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed 5x5 frame, 3x3 window: corners see too few neighbors
      configure(5, 5, 1, 12288);
      for (int i = 0; i < 25; i++) begin
         if (i == 12) queue_pixel(24'h7FFFFF, 0);
         else if (i == 7) queue_pixel(24'h800000, 0);
         else if (i == 3 || i == 17) queue_pixel(24'h000100, 1);
         else if (i == 20) begin
            it.drain = 1;
            it.value = 24'hFFFFFF;
            it.masked = 1;
            pending_items.insert(pending_items.size(), it);
            queue_pixel(24'h000040, 0);
         end else queue_pixel((i < 10) ? 24'h000040 : 24'(i * 8), 0);
      end
      for (int i = 0; i < 6; i++) begin
         it.drain = i[0];
         it.value = 24'h123456;
         it.masked = 0;
         pending_items.insert(pending_items.size(), it);
      end
      wait_idle();

      // wide and tall strips, smallest frame
      configure(128, 2, 3, 65535);
      void'(queue_frame(1, 5));
      wait_idle();
      configure(1, 160, 1, 0);
      void'(queue_frame(0, 5));
      wait_idle();
      configure(1, 1, 3, 4096);
      void'(queue_frame(0, 0));
      wait_idle();

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 5))
            0: sig = 0;
            1: sig = 65535;
            2: sig = $urandom_range(0, 65535);
            default: sig = $urandom_range(2048, 16384);
         endcase
         configure($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(1, 3), sig);
         repeat ($urandom_range(1, 3))
            random_count += queue_frame($urandom_range(0, 2),
                                        ($urandom_range(0, 2) == 0) ? 40 : $urandom_range(0, 10));
         wait_idle();
      end

      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
